/* sv/bpim_pkg.sv */
// ----------------------------------------------------------------------------
// bpim_pkg
// Shared types, constants and helper functions for the partition index map.
// ----------------------------------------------------------------------------
package bpim_pkg;

  localparam int CW   = 17;   // cell / index width
  localparam int KW   = 9;    // chunk count width
  localparam int BKW  = 8;    // chunk index width
  localparam int EW   = 9;    // remainder width
  localparam int IW   = 8;    // config index width
  localparam int QMAX = 16;   // widest quotient carried in a stage

  localparam int MAX_CELLS_DEF  = 65536;
  localparam int MAX_CHUNKS_DEF = 256;

  localparam logic [CW-1:0] CELLS_RST  = CW'(64);
  localparam logic [KW-1:0] CHUNKS_RST = KW'(1);

  localparam logic [IW-1:0] CFG_CELLS_X  = IW'(0);
  localparam logic [IW-1:0] CFG_CELLS_Y  = IW'(1);
  localparam logic [IW-1:0] CFG_CHUNKS_X = IW'(2);
  localparam logic [IW-1:0] CFG_CHUNKS_Y = IW'(3);

  typedef enum logic [1:0] {
    REQ_CELL_G2L  = 2'd0,
    REQ_POINT_G2L = 2'd1,
    REQ_CELL_L2G  = 2'd2,
    REQ_POINT_L2G = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    DRV_IDLE,
    DRV_LOAD,
    DRV_DIV,
    DRV_MUL
  } drv_state_t;

  typedef struct packed {
    logic [CW-1:0] cells_x;
    logic [CW-1:0] cells_y;
    logic [KW-1:0] chunks_x;
    logic [KW-1:0] chunks_y;
    logic          ok_x;
    logic          ok_y;
    logic [CW-1:0] bw_x;
    logic [CW-1:0] bw_y;
    logic [EW-1:0] ex_x;
    logic [EW-1:0] ex_y;
    logic [CW-1:0] co_x;
    logic [CW-1:0] co_y;
  } geom_t;

  typedef struct packed {
    logic            vld;
    logic            l2g;
    logic            ok;
    logic [CW-1:0]   rem_x;
    logic [CW-1:0]   rem_y;
    logic [CW-1:0]   div_x;
    logic [CW-1:0]   div_y;
    logic [QMAX-1:0] q_x;
    logic [QMAX-1:0] q_y;
    logic [EW-1:0]   add_x;
    logic [EW-1:0]   add_y;
    logic            inc_x;
    logic            inc_y;
    logic [CW-1:0]   glb_x;
    logic [CW-1:0]   glb_y;
  } stage_t;

  typedef struct packed {
    logic          ok;
    logic [CW-1:0] rem;
    logic [CW-1:0] div;
    logic [EW-1:0] add;
    logic          inc;
  } g2l_t;

  typedef struct packed {
    logic          ok;
    logic [CW-1:0] glb;
  } l2g_t;

  function automatic logic axis_ok(input logic [CW-1:0] cells,
                                   input logic [KW-1:0] chunks,
                                   input int max_cells, input int max_chunks);
    logic [31:0] c;
    logic [31:0] k;
    c = 32'(cells);
    k = 32'(chunks);
    return (c >= 32'd1) && (c <= 32'(max_cells)) && (k >= 32'd1) &&
           (k <= 32'(max_chunks)) && (k <= c);
  endfunction

  function automatic g2l_t axis_g2l(input logic [CW-1:0] coord,
                                    input logic [CW-1:0] cells,
                                    input logic [CW-1:0] bw,
                                    input logic [EW-1:0] ex,
                                    input logic [CW-1:0] co,
                                    input logic pt);
    g2l_t          r;
    logic [CW-1:0] m;
    r.ok  = pt ? (coord <= cells) : (coord < cells);
    r.inc = pt && (coord != '0);
    m     = r.inc ? coord - CW'(1) : coord;
    if (m < co) begin
      r.rem = m;
      r.div = bw + CW'(1);
      r.add = '0;
    end else begin
      r.rem = m - co;
      r.div = bw;
      r.add = ex;
    end
    return r;
  endfunction

  function automatic l2g_t axis_l2g(input logic [BKW-1:0] blk,
                                    input logic [CW-1:0] loc,
                                    input logic [KW-1:0] chunks,
                                    input logic [CW-1:0] bw,
                                    input logic [EW-1:0] ex,
                                    input logic [CW-1:0] co,
                                    input logic pt);
    l2g_t          r;
    logic [CW:0]   lim;
    logic [CW+BKW:0] g;
    if (blk < ex) begin
      lim = {1'b0, bw} + (CW+1)'(1) + (CW+1)'(pt);
      g   = (CW+BKW+1)'(({1'b0, bw} + (CW+1)'(1)) * blk) + (CW+BKW+1)'(loc);
    end else begin
      lim = {1'b0, bw} + (CW+1)'(pt);
      g   = (CW+BKW+1)'(bw * (blk - ex)) + (CW+BKW+1)'(co) + (CW+BKW+1)'(loc);
    end
    r.ok  = ({1'b0, blk} < chunks) && ({1'b0, loc} < lim);
    r.glb = g[CW-1:0];
    return r;
  endfunction

endpackage

/* sv/bpim_ifs.sv */
// ----------------------------------------------------------------------------
// bpim request / result interfaces
// Valid/ready channels carrying one request word and one result word.
// ----------------------------------------------------------------------------
interface bpim_req_if import bpim_pkg::*; ;
  logic           valid;
  logic           ready;
  logic [1:0]     req_type;
  logic [CW-1:0]  coord_x;
  logic [CW-1:0]  coord_y;
  logic [BKW-1:0] block_x;
  logic [BKW-1:0] block_y;
  logic [CW-1:0]  local_x;
  logic [CW-1:0]  local_y;

  modport source(output valid, req_type, coord_x, coord_y, block_x, block_y,
                 local_x, local_y, input ready);
  modport sink(input valid, req_type, coord_x, coord_y, block_x, block_y,
               local_x, local_y, output ready);
endinterface

interface bpim_res_if import bpim_pkg::*; ;
  logic           valid;
  logic           ready;
  logic           valid_res;
  logic [BKW-1:0] res_block_x;
  logic [BKW-1:0] res_block_y;
  logic [CW-1:0]  res_local_x;
  logic [CW-1:0]  res_local_y;
  logic [CW-1:0]  res_global_x;
  logic [CW-1:0]  res_global_y;

  modport source(output valid, valid_res, res_block_x, res_block_y, res_local_x,
                 res_local_y, res_global_x, res_global_y, input ready);
  modport sink(input valid, valid_res, res_block_x, res_block_y, res_local_x,
               res_local_y, res_global_x, res_global_y, output ready);
endinterface

/* sv/bpim_cell.sv */
// ----------------------------------------------------------------------------
// bpim_cell
// One restoring division step on both axes; registered stage of the chain.
// ----------------------------------------------------------------------------
module bpim_cell import bpim_pkg::*; #(
  parameter int SH = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  stage_t d_i,
  output stage_t q_o
);

  localparam int DW = CW + SH;

  stage_t        s_r;
  stage_t        s_nxt;
  logic [DW-1:0] dsh_x;
  logic [DW-1:0] dsh_y;

  always_comb begin
    s_nxt = d_i;
    dsh_x = DW'(d_i.div_x) << SH;
    dsh_y = DW'(d_i.div_y) << SH;
    if (DW'(d_i.rem_x) >= dsh_x) begin
      s_nxt.rem_x   = CW'(DW'(d_i.rem_x) - dsh_x);
      s_nxt.q_x[SH] = 1'b1;
    end
    if (DW'(d_i.rem_y) >= dsh_y) begin
      s_nxt.rem_y   = CW'(DW'(d_i.rem_y) - dsh_y);
      s_nxt.q_y[SH] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.vld <= 1'b0;
    end else if (en) begin
      s_r <= s_nxt;
    end
  end

  assign q_o = s_r;

endmodule

/* sv/bpim_derive.sv */
// ----------------------------------------------------------------------------
// bpim_derive
// Config registers and serial derivation of width, remainder and cutoff.
// ----------------------------------------------------------------------------
module bpim_derive import bpim_pkg::*; #(
  parameter int MAX_CELLS  = MAX_CELLS_DEF,
  parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [IW-1:0] cfg_idx,
  input  logic [CW-1:0] cfg_wdata,
  output geom_t         geom_o,
  output logic          busy_o
);

  localparam int NW = $clog2(CW);
  localparam logic RST_OK = (MAX_CELLS >= int'(CELLS_RST)) &&
                            (MAX_CHUNKS >= int'(CHUNKS_RST));

  drv_state_t    state_r, state_nxt;
  logic [NW-1:0] cnt_r;
  logic [CW-1:0] n_x_r, n_y_r, q_x_r, q_y_r;
  logic [KW-1:0] r_x_r, r_y_r;
  geom_t         g_r;
  logic          wr_hit;
  logic [KW:0]   t_x, t_y;
  logic          ok_x, ok_y;

  assign wr_hit = cfg_we && ((cfg_idx == CFG_CELLS_X) || (cfg_idx == CFG_CELLS_Y) ||
                  (cfg_idx == CFG_CHUNKS_X) || (cfg_idx == CFG_CHUNKS_Y));

  always_comb begin
    state_nxt = state_r;
    if (wr_hit) begin
      state_nxt = DRV_LOAD;
    end else begin
      case (state_r)
        DRV_IDLE: state_nxt = DRV_IDLE;
        DRV_LOAD: state_nxt = DRV_DIV;
        DRV_DIV:  if (cnt_r == NW'(CW-1)) state_nxt = DRV_MUL;
        DRV_MUL:  state_nxt = DRV_IDLE;
        default:  state_nxt = DRV_IDLE;
      endcase
    end
  end

  always_comb begin
    case (state_r)
      DRV_IDLE: busy_o = 1'b0;
      default:  busy_o = 1'b1;
    endcase
  end

  assign t_x  = {r_x_r, n_x_r[CW-1]};
  assign t_y  = {r_y_r, n_y_r[CW-1]};
  assign ok_x = axis_ok(g_r.cells_x, g_r.chunks_x, MAX_CELLS, MAX_CHUNKS);
  assign ok_y = axis_ok(g_r.cells_y, g_r.chunks_y, MAX_CELLS, MAX_CHUNKS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= DRV_IDLE;
      g_r.cells_x  <= CELLS_RST;
      g_r.cells_y  <= CELLS_RST;
      g_r.chunks_x <= CHUNKS_RST;
      g_r.chunks_y <= CHUNKS_RST;
      g_r.ok_x <= RST_OK;
      g_r.ok_y <= RST_OK;
      g_r.bw_x <= RST_OK ? CELLS_RST : '0;
      g_r.bw_y <= RST_OK ? CELLS_RST : '0;
      g_r.ex_x <= '0;
      g_r.ex_y <= '0;
      g_r.co_x <= '0;
      g_r.co_y <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_CELLS_X:  g_r.cells_x  <= cfg_wdata;
          CFG_CELLS_Y:  g_r.cells_y  <= cfg_wdata;
          CFG_CHUNKS_X: g_r.chunks_x <= cfg_wdata[KW-1:0];
          CFG_CHUNKS_Y: g_r.chunks_y <= cfg_wdata[KW-1:0];
          default: ;
        endcase
      end
      if (state_r == DRV_MUL) begin
        g_r.ok_x <= ok_x;
        g_r.ok_y <= ok_y;
        g_r.bw_x <= ok_x ? q_x_r : '0;
        g_r.bw_y <= ok_y ? q_y_r : '0;
        g_r.ex_x <= ok_x ? r_x_r[EW-1:0] : '0;
        g_r.ex_y <= ok_y ? r_y_r[EW-1:0] : '0;
        g_r.co_x <= ok_x ? CW'(r_x_r[EW-1:0] * (q_x_r + CW'(1))) : '0;
        g_r.co_y <= ok_y ? CW'(r_y_r[EW-1:0] * (q_y_r + CW'(1))) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == DRV_LOAD) begin
      cnt_r <= '0;
      n_x_r <= g_r.cells_x;
      n_y_r <= g_r.cells_y;
      r_x_r <= '0;
      r_y_r <= '0;
      q_x_r <= '0;
      q_y_r <= '0;
    end else if (state_r == DRV_DIV) begin
      cnt_r <= cnt_r + NW'(1);
      n_x_r <= n_x_r << 1;
      n_y_r <= n_y_r << 1;
      if (t_x >= {1'b0, g_r.chunks_x}) begin
        r_x_r <= KW'(t_x - {1'b0, g_r.chunks_x});
        q_x_r <= {q_x_r[CW-2:0], 1'b1};
      end else begin
        r_x_r <= t_x[KW-1:0];
        q_x_r <= {q_x_r[CW-2:0], 1'b0};
      end
      if (t_y >= {1'b0, g_r.chunks_y}) begin
        r_y_r <= KW'(t_y - {1'b0, g_r.chunks_y});
        q_y_r <= {q_y_r[CW-2:0], 1'b1};
      end else begin
        r_y_r <= t_y[KW-1:0];
        q_y_r <= {q_y_r[CW-2:0], 1'b0};
      end
    end
  end

  assign geom_o = g_r;

endmodule

/* sv/block_partition_index_map.sv */
// ----------------------------------------------------------------------------
// block_partition_index_map
// Balanced 2D chunk partition: global <-> chunk/local index translation.
// ----------------------------------------------------------------------------
//  port    dir  kind        word
//  in_if   in   valid/ready request: type, global coords, chunk, local
//  out_if  out  valid/ready result: flag, chunk, local, global
//  cfg_*   in   write only  cells_x, cells_y, chunks_x, chunks_y
//
//  One word per cycle unless the output stalls or a derivation runs; words
//  pass the chain of division cells (one quotient bit per cell), then a register.
//  A config write starts a serial derivation (load, divide, multiply); in_if.ready
//  is low meanwhile. After reset the derived state is ready at once.
//  A stalled output holds the whole chain; ready follows out_if.ready.
// ----------------------------------------------------------------------------
module block_partition_index_map import bpim_pkg::*; #(
  parameter int MAX_CELLS  = MAX_CELLS_DEF,
  parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  bpim_req_if.sink      in_if,
  bpim_res_if.source    out_if,
  input  logic          cfg_we,
  input  logic [IW-1:0] cfg_idx,
  input  logic [CW-1:0] cfg_wdata
);

  localparam int QW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

  geom_t    geom;
  logic     busy;
  logic     en;
  stage_t   chain [0:QW];
  stage_t   last;
  g2l_t     gx, gy;
  l2g_t     lx, ly;
  req_t     req;
  logic     l2g, pt;
  logic     out_v_r;
  logic     res_ok_r;
  logic [BKW-1:0] blk_x_r, blk_y_r;
  logic [CW-1:0]  loc_x_r, loc_y_r, glb_x_r, glb_y_r;
  logic [QMAX-1:0] bsum_x, bsum_y;

  bpim_derive #(.MAX_CELLS(MAX_CELLS), .MAX_CHUNKS(MAX_CHUNKS)) u_derive (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata), .geom_o(geom), .busy_o(busy)
  );

  assign en          = !out_v_r || out_if.ready;
  assign in_if.ready = en && !busy;

  assign req = req_t'(in_if.req_type);
  assign l2g = (req == REQ_CELL_L2G) || (req == REQ_POINT_L2G);
  assign pt  = (req == REQ_POINT_G2L) || (req == REQ_POINT_L2G);

  always_comb begin
    gx = axis_g2l(in_if.coord_x, geom.cells_x, geom.bw_x, geom.ex_x, geom.co_x, pt);
    gy = axis_g2l(in_if.coord_y, geom.cells_y, geom.bw_y, geom.ex_y, geom.co_y, pt);
    lx = axis_l2g(in_if.block_x, in_if.local_x, geom.chunks_x, geom.bw_x, geom.ex_x,
                  geom.co_x, pt);
    ly = axis_l2g(in_if.block_y, in_if.local_y, geom.chunks_y, geom.bw_y, geom.ex_y,
                  geom.co_y, pt);
    chain[0].vld   = in_if.valid && in_if.ready;
    chain[0].l2g   = l2g;
    chain[0].ok    = geom.ok_x && geom.ok_y &&
                     (l2g ? (lx.ok && ly.ok) : (gx.ok && gy.ok));
    chain[0].rem_x = gx.rem;
    chain[0].rem_y = gy.rem;
    chain[0].div_x = gx.div;
    chain[0].div_y = gy.div;
    chain[0].q_x   = '0;
    chain[0].q_y   = '0;
    chain[0].add_x = gx.add;
    chain[0].add_y = gy.add;
    chain[0].inc_x = gx.inc;
    chain[0].inc_y = gy.inc;
    chain[0].glb_x = lx.glb;
    chain[0].glb_y = ly.glb;
  end

  for (genvar i = 0; i < QW; i++) begin : g_cell
    bpim_cell #(.SH(QW-1-i)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .d_i(chain[i]), .q_o(chain[i+1])
    );
  end

  assign last   = chain[QW];
  assign bsum_x = last.q_x + QMAX'(last.add_x);
  assign bsum_y = last.q_y + QMAX'(last.add_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= last.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_ok_r <= last.ok;
      blk_x_r  <= (last.ok && !last.l2g) ? bsum_x[BKW-1:0] : '0;
      blk_y_r  <= (last.ok && !last.l2g) ? bsum_y[BKW-1:0] : '0;
      loc_x_r  <= (last.ok && !last.l2g) ? last.rem_x + CW'(last.inc_x) : '0;
      loc_y_r  <= (last.ok && !last.l2g) ? last.rem_y + CW'(last.inc_y) : '0;
      glb_x_r  <= (last.ok && last.l2g) ? last.glb_x : '0;
      glb_y_r  <= (last.ok && last.l2g) ? last.glb_y : '0;
    end
  end

  assign out_if.valid        = out_v_r;
  assign out_if.valid_res    = res_ok_r;
  assign out_if.res_block_x  = blk_x_r;
  assign out_if.res_block_y  = blk_y_r;
  assign out_if.res_local_x  = loc_x_r;
  assign out_if.res_local_y  = loc_y_r;
  assign out_if.res_global_x = glb_x_r;
  assign out_if.res_global_y = glb_y_r;

  a_zero_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !res_ok_r) |-> (blk_x_r == '0 && blk_y_r == '0 && loc_x_r == '0 &&
      loc_y_r == '0 && glb_x_r == '0 && glb_y_r == '0))
    else $error("miss result carries nonzero fields");

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_idx == CFG_CELLS_X || cfg_idx == CFG_CHUNKS_Y)) |=> busy)
    else $error("config write did not start derivation");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !chain[0].vld)
    else $error("request taken during derivation");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_v_r))
    else $error("not idle after reset");

endmodule
